### rtl/sbc_pkg.sv
// Shared types and constants for the sphere/box collision test pipeline.
`default_nettype none

package sbc_pkg;

	// Width of one packed corner or center field
	localparam int FIELD_W = 48;

	// Default width of one fixed-point coordinate (Q8.8)
	localparam int COORD_BITS_DEF = 16;

	// Collider kind codes on the request
	localparam logic [1:0] COL_SPHERE = 2'd0;
	localparam logic [1:0] COL_BOX    = 2'd1;

	// Test kind reported with each result
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_SS   = 2'd1,
		KIND_BB   = 2'd2,
		KIND_SB   = 2'd3
	} kind_t;

	// One request: a pair of colliders
	typedef struct packed {
		logic [1:0]         a_type;
		logic [FIELD_W-1:0] a_lo;
		logic [FIELD_W-1:0] a_hi;
		logic [1:0]         b_type;
		logic [FIELD_W-1:0] b_lo;
		logic [FIELD_W-1:0] b_hi;
	} req_t;

	// One result
	typedef struct packed {
		logic  hit;
		kind_t test_kind;
	} result_t;

	// Control that travels down the pipeline with the data
	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  bb_hit;
	} ctl_t;

endpackage

`default_nettype wire

### rtl/sbc_front.sv
// Front stages: decode, role swap, unpack, box overlap, clamp and radius (summed for two spheres).
`default_nettype none

module sbc_front import sbc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  req_t                         req,
	output ctl_t                         ctl_s2,
	output logic signed [COORD_BITS-1:0] ctr_s2 [0:2],
	output logic signed [COORD_BITS-1:0] pt_s2  [0:2],
	output logic        [COORD_BITS:0]   rad_s2
);

	localparam int EXT_W = 3 * COORD_BITS + FIELD_W;

	// Stage 1 combinational: decode and swap so the sphere comes first
	logic               swap;
	kind_t              kind;
	logic [FIELD_W-1:0] s_lo, s_hi, o_lo, o_hi;
	logic [EXT_W-1:0]   s_lo_x, s_hi_x, o_lo_x, o_hi_x;
	logic signed [COORD_BITS-1:0] s_lo_c [0:2];
	logic signed [COORD_BITS-1:0] s_hi_c [0:2];
	logic signed [COORD_BITS-1:0] o_lo_c [0:2];
	logic signed [COORD_BITS-1:0] o_hi_c [0:2];
	logic               bb_hit;

	always_comb begin
		swap = (req.a_type == COL_BOX) && (req.b_type == COL_SPHERE);
		if ((req.a_type == COL_SPHERE) && (req.b_type == COL_SPHERE)) begin
			kind = KIND_SS;
		end else if ((req.a_type == COL_BOX) && (req.b_type == COL_BOX)) begin
			kind = KIND_BB;
		end else if (swap || ((req.a_type == COL_SPHERE) && (req.b_type == COL_BOX))) begin
			kind = KIND_SB;
		end else begin
			kind = KIND_NONE;
		end
		s_lo = swap ? req.b_lo : req.a_lo;
		s_hi = swap ? req.b_hi : req.a_hi;
		o_lo = swap ? req.a_lo : req.b_lo;
		o_hi = swap ? req.a_hi : req.b_hi;
		// Coordinate bits beyond the field read as zero
		s_lo_x = {{(3 * COORD_BITS){1'b0}}, s_lo};
		s_hi_x = {{(3 * COORD_BITS){1'b0}}, s_hi};
		o_lo_x = {{(3 * COORD_BITS){1'b0}}, o_lo};
		o_hi_x = {{(3 * COORD_BITS){1'b0}}, o_hi};
		bb_hit = 1'b1;
		for (int k = 0; k < 3; k++) begin
			s_lo_c[k] = s_lo_x[k*COORD_BITS +: COORD_BITS];
			s_hi_c[k] = s_hi_x[k*COORD_BITS +: COORD_BITS];
			o_lo_c[k] = o_lo_x[k*COORD_BITS +: COORD_BITS];
			o_hi_c[k] = o_hi_x[k*COORD_BITS +: COORD_BITS];
			// Inclusive overlap on every axis, no reordering of corners
			if (!((s_lo_c[k] <= o_hi_c[k]) && (s_hi_c[k] >= o_lo_c[k]))) begin
				bb_hit = 1'b0;
			end
		end
	end

	// Stage 1 registers
	ctl_t ctl_s1;
	logic signed [COORD_BITS-1:0] ctr_s1 [0:2];
	logic signed [COORD_BITS-1:0] mn_s1  [0:2];
	logic signed [COORD_BITS-1:0] mx_s1  [0:2];
	logic        [COORD_BITS-1:0] ra_s1, rb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.kind   <= kind;
			ctl_s1.bb_hit <= bb_hit;
		end
	end

	always_ff @(posedge clk) begin
		ctr_s1        <= s_lo_c;
		mn_s1         <= o_lo_c;
		mx_s1         <= o_hi_c;
		ra_s1         <= s_hi[COORD_BITS-1:0];
		rb_s1         <= o_hi[COORD_BITS-1:0];
	end

	// Stage 2 combinational: nearest point and radius, summed for two spheres
	logic signed [COORD_BITS-1:0] pt [0:2];
	logic signed [COORD_BITS-1:0] lim;
	logic        [COORD_BITS:0]   rad;

	always_comb begin
		lim = '0;
		for (int k = 0; k < 3; k++) begin
			lim = (ctr_s1[k] < mx_s1[k]) ? ctr_s1[k] : mx_s1[k];
			if (ctl_s1.kind == KIND_SS) begin
				pt[k] = mn_s1[k];
			end else begin
				pt[k] = (lim < mn_s1[k]) ? mn_s1[k] : lim;
			end
		end
		if (ctl_s1.kind == KIND_SS) begin
			rad = {1'b0, ra_s1} + {1'b0, rb_s1};
		end else begin
			rad = {1'b0, ra_s1};
		end
	end

	// Stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid  <= ctl_s1.valid;
			ctl_s2.kind   <= ctl_s1.kind;
			ctl_s2.bb_hit <= ctl_s1.bb_hit;
		end
	end

	always_ff @(posedge clk) begin
		ctr_s2        <= ctr_s1;
		pt_s2         <= pt;
		rad_s2        <= rad;
	end

endmodule

`default_nettype wire

### rtl/sbc_dist.sv
// Back stages: axis distances, squares, sum and final compare.
`default_nettype none

module sbc_dist import sbc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ctl_t                         ctl_s2,
	input  wire signed [COORD_BITS-1:0]  ctr_s2 [0:2],
	input  wire signed [COORD_BITS-1:0]  pt_s2  [0:2],
	input  wire        [COORD_BITS:0]    rad_s2,
	output logic                         done,
	output result_t                      result
);

	localparam int MAG_W = COORD_BITS + 1;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int SUM_W = SQ_W + 2;

	// Stage 3: absolute difference per axis
	logic [MAG_W-1:0] mag [0:2];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctr_s2[k] >= pt_s2[k]) begin
				mag[k] = MAG_W'({ctr_s2[k][COORD_BITS-1], ctr_s2[k]}
					- {pt_s2[k][COORD_BITS-1], pt_s2[k]});
			end else begin
				mag[k] = MAG_W'({pt_s2[k][COORD_BITS-1], pt_s2[k]}
					- {ctr_s2[k][COORD_BITS-1], ctr_s2[k]});
			end
		end
	end

	ctl_t             ctl_s3;
	logic [MAG_W-1:0] mag_s3 [0:2];
	logic [MAG_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3.valid  <= ctl_s2.valid;
			ctl_s3.kind   <= ctl_s2.kind;
			ctl_s3.bb_hit <= ctl_s2.bb_hit;
		end
	end

	always_ff @(posedge clk) begin
		mag_s3        <= mag;
		rad_s3        <= rad_s2;
	end

	// Stage 4: squares
	ctl_t            ctl_s4;
	logic [SQ_W-1:0] sq_s4 [0:2];
	logic [SQ_W-1:0] rsq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4.valid  <= ctl_s3.valid;
			ctl_s4.kind   <= ctl_s3.kind;
			ctl_s4.bb_hit <= ctl_s3.bb_hit;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s4[k] <= SQ_W'(mag_s3[k] * mag_s3[k]);
		end
		rsq_s4 <= SQ_W'(rad_s3 * rad_s3);
	end

	// Stage 5: sum, strict compare, pick by test kind
	logic [SUM_W-1:0] sq_sum;
	logic             hit;

	always_comb begin
		sq_sum = {2'b00, sq_s4[0]} + {2'b00, sq_s4[1]} + {2'b00, sq_s4[2]};
		case (ctl_s4.kind)
			KIND_SS, KIND_SB: hit = sq_sum < {2'b00, rsq_s4};
			KIND_BB:          hit = ctl_s4.bb_hit;
			default:          hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		result.hit       <= hit;
		result.test_kind <= ctl_s4.kind;
	end

endmodule

`default_nettype wire

### rtl/sphere_box_collision_test.sv
// Top level of the sphere/box narrow-phase collision test.
//
//   channel   ports               handshake
//   request   req (req_t)         taken when start && !busy
//   result    result (result_t)   valid for one cycle while done is high
//
// One request per clock. A request's result reaches the ports through five register
// stages (decode and box overlap, clamp, axis distance, squaring, sum and
// compare), with the squarer stage holding the multipliers. busy stays low:
// the pipeline holds no state between pairs and the receiver cannot stall it.
// Reset clears the per-stage control (valid, kind, box flag) and done.
`default_nettype none

module sphere_box_collision_test import sbc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     start,
	output logic    busy,
	input  req_t    req,
	output logic    done,
	output result_t result
);

	ctl_t                         ctl_s2;
	logic signed [COORD_BITS-1:0] ctr_s2 [0:2];
	logic signed [COORD_BITS-1:0] pt_s2  [0:2];
	logic        [COORD_BITS:0]   rad_s2;

	// Never hold off a request
	assign busy = 1'b0;

	sbc_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.req      (req),
		.ctl_s2   (ctl_s2),
		.ctr_s2   (ctr_s2),
		.pt_s2    (pt_s2),
		.rad_s2   (rad_s2)
	);

	sbc_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.ctr_s2 (ctr_s2),
		.pt_s2  (pt_s2),
		.rad_s2 (rad_s2),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire
